### src/tapq_pkg.sv
// shared types, constants and helpers for the three-axis pid quad mixer
`timescale 1ns / 1ps

package tapq_pkg;

   // fixed field widths
   localparam int SAMPLE_WIDTH    = 16;
   localparam int GAIN_WIDTH      = 16;
   localparam int GAINS_WIDTH     = 3 * GAIN_WIDTH;
   localparam int CMD_WIDTH       = 8;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CMD_MAX         = 255;

   // default for the integrator width parameter
   localparam int INTEGRAL_WIDTH  = 32;

   // gain packing: kp high, ki middle, kd low
   localparam int KP_LSB = 2 * GAIN_WIDTH;
   localparam int KI_LSB = GAIN_WIDTH;
   localparam int KD_LSB = 0;

   // register reset values
   localparam logic [GAINS_WIDTH-1:0]         HEIGHT_GAINS_RESET  = 48'h0300_0100_0100;
   localparam logic [GAINS_WIDTH-1:0]         ANGLE_GAINS_RESET   = 48'h004D_001A_001A;
   localparam logic signed [SAMPLE_WIDTH-1:0] TARGET_HEIGHT_RESET = 16'sd100;
   localparam logic signed [SAMPLE_WIDTH-1:0] TARGET_ANGLE_RESET  = 16'sd0;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_HEIGHT_GAINS  = 3'd0,
      CSR_PITCH_GAINS   = 3'd1,
      CSR_ROLL_GAINS    = 3'd2,
      CSR_TARGET_HEIGHT = 3'd3,
      CSR_TARGET_PITCH  = 3'd4,
      CSR_TARGET_ROLL   = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] height_sample;
      logic signed [SAMPLE_WIDTH-1:0] pitch_sample;
      logic signed [SAMPLE_WIDTH-1:0] roll_sample;
   } req_type;

   typedef struct packed {
      logic [CMD_WIDTH-1:0] front_left;
      logic [CMD_WIDTH-1:0] front_right;
      logic [CMD_WIDTH-1:0] back_left;
      logic [CMD_WIDTH-1:0] back_right;
   } rsp_type;

   // pipeline control from the top level to the datapath
   typedef struct packed {
      logic accept;
      logic advance;
   } pipe_ctrl_type;

   function automatic int max_int(input int a, input int b);
      return (a > b) ? a : b;
   endfunction

   // width of one axis effort in q.8: widest product plus growth for three terms
   function automatic int effort_width(input int iw);
      return GAIN_WIDTH + 1 + max_int(iw, SAMPLE_WIDTH + 2) + 2;
   endfunction

endpackage

### src/tapq_axis.sv
// one pid axis: error, saturating integral, delta, gain products and effort sum
`timescale 1ns / 1ps

module tapq_axis #(
   parameter int  INTEGRAL_WIDTH = tapq_pkg::INTEGRAL_WIDTH,
   localparam int EFFORT_WIDTH   = tapq_pkg::effort_width(INTEGRAL_WIDTH)
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  tapq_pkg::pipe_ctrl_type                    ctrl,
   input  logic [tapq_pkg::GAINS_WIDTH-1:0]           gains,
   input  logic signed [tapq_pkg::SAMPLE_WIDTH-1:0]   target,
   input  logic signed [tapq_pkg::SAMPLE_WIDTH-1:0]   sample,
   output logic signed [EFFORT_WIDTH-1:0]             effort
);

   localparam int SW      = tapq_pkg::SAMPLE_WIDTH;
   localparam int GW      = tapq_pkg::GAIN_WIDTH;
   localparam int IW      = INTEGRAL_WIDTH;
   localparam int ERR_W   = SW + 1;
   localparam int DELTA_W = SW + 2;
   localparam int SUM_W   = tapq_pkg::max_int(IW, ERR_W) + 1;
   localparam int PP_W    = GW + 1 + ERR_W;
   localparam int PI_W    = GW + 1 + IW;
   localparam int PD_W    = GW + 1 + DELTA_W;

   localparam logic signed [IW-1:0] IMAX = {1'b0, {(IW-1){1'b1}}};
   localparam logic signed [IW-1:0] IMIN = {1'b1, {(IW-1){1'b0}}};

   // controller state
   logic signed [IW-1:0]      integral_ff;
   logic signed [ERR_W-1:0]   last_ff;

   // stage one
   logic signed [ERR_W-1:0]   err_in, err_ff;
   logic signed [SUM_W-1:0]   sum_in;
   logic signed [IW-1:0]      acc_in, acc_ff;
   logic signed [DELTA_W-1:0] delta_in, delta_ff;

   // stage two
   logic signed [GW:0]        kp_s, ki_s, kd_s;
   logic signed [PP_W-1:0]    prod_p_in, prod_p_ff;
   logic signed [PI_W-1:0]    prod_i_in, prod_i_ff;
   logic signed [PD_W-1:0]    prod_d_in, prod_d_ff;

   // stage three
   logic signed [EFFORT_WIDTH-1:0] effort_in, effort_ff;

   always_comb begin
      err_in   = ERR_W'(target) - ERR_W'(sample);
      sum_in   = SUM_W'(integral_ff) + SUM_W'(err_in);
      if (sum_in > SUM_W'(IMAX)) begin
         acc_in = IMAX;
      end else if (sum_in < SUM_W'(IMIN)) begin
         acc_in = IMIN;
      end else begin
         acc_in = sum_in[IW-1:0];
      end
      delta_in = DELTA_W'(err_in) - DELTA_W'(last_ff);
   end

   always_comb begin
      kp_s      = {1'b0, gains[tapq_pkg::KP_LSB +: GW]};
      ki_s      = {1'b0, gains[tapq_pkg::KI_LSB +: GW]};
      kd_s      = {1'b0, gains[tapq_pkg::KD_LSB +: GW]};
      prod_p_in = kp_s * err_ff;
      prod_i_in = ki_s * acc_ff;
      prod_d_in = kd_s * delta_ff;
      effort_in = EFFORT_WIDTH'(prod_p_ff) + EFFORT_WIDTH'(prod_i_ff)
                + EFFORT_WIDTH'(prod_d_ff);
   end

   // state moves only with an accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         integral_ff <= '0;
         last_ff     <= '0;
      end else if (ctrl.accept) begin
         integral_ff <= acc_in;
         last_ff     <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.advance) begin
         err_ff    <= err_in;
         acc_ff    <= acc_in;
         delta_ff  <= delta_in;
         prod_p_ff <= prod_p_in;
         prod_i_ff <= prod_i_in;
         prod_d_ff <= prod_d_in;
         effort_ff <= effort_in;
      end
   end

   assign effort = effort_ff;

`ifndef SYNTHESIS
   state_holds_without_item: assert property (
      @(posedge clock) disable iff (reset)
      !ctrl.accept |=> ($stable(integral_ff) && $stable(last_ff))
   ) else $error("axis state changed without an accepted item");
`endif

endmodule

### src/tapq_mix.sv
// x-frame rotor mixer with floor and clamp, feeding the result register
`timescale 1ns / 1ps

module tapq_mix #(
   parameter int  INTEGRAL_WIDTH = tapq_pkg::INTEGRAL_WIDTH,
   localparam int EFFORT_WIDTH   = tapq_pkg::effort_width(INTEGRAL_WIDTH)
) (
   input  logic                           clock,
   input  tapq_pkg::pipe_ctrl_type        ctrl,
   input  logic signed [EFFORT_WIDTH-1:0] height_effort,
   input  logic signed [EFFORT_WIDTH-1:0] pitch_effort,
   input  logic signed [EFFORT_WIDTH-1:0] roll_effort,
   output tapq_pkg::rsp_type              rsp
);

   localparam int MW = EFFORT_WIDTH + 2;
   localparam int CW = tapq_pkg::CMD_WIDTH;

   logic signed [MW-1:0] h, p, r;
   logic signed [MW-1:0] sum_fl, sum_fr, sum_bl, sum_br;
   tapq_pkg::rsp_type    rsp_in, rsp_ff;

   // floor of q.8 is the integer part, then clamp to the command range
   function automatic logic [CW-1:0] to_cmd(input logic signed [MW-1:0] s);
      logic [MW-9:0] whole;
      whole = s[MW-1:8];
      if (s < 0) begin
         return '0;
      end else if (whole > (MW-8)'(tapq_pkg::CMD_MAX)) begin
         return CW'(tapq_pkg::CMD_MAX);
      end else begin
         return whole[CW-1:0];
      end
   endfunction

   always_comb begin
      h      = MW'(height_effort);
      p      = MW'(pitch_effort);
      r      = MW'(roll_effort);
      sum_fl = h - p + r;
      sum_fr = h - p - r;
      sum_bl = h + p + r;
      sum_br = h + p - r;
      rsp_in.front_left  = to_cmd(sum_fl);
      rsp_in.front_right = to_cmd(sum_fr);
      rsp_in.back_left   = to_cmd(sum_bl);
      rsp_in.back_right  = to_cmd(sum_br);
   end

   always_ff @(posedge clock) begin
      if (ctrl.advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp = rsp_ff;

endmodule

### src/three_axis_pid_quad_mixer.sv
// top level: config registers, pipeline control, three pid axes and the rotor mixer
`timescale 1ns / 1ps

// pipeline: an accepted input item passes through these registered stages in order
//    (error/integral stage, gain multiply stage, effort sum stage, mix and clamp stage)
// throughput: one item per cycle while rsp_ready is high; a stalled output stalls all stages
// reset: synchronous; clears integrals, last errors and stage valids, loads default gains
//    and targets; no result is pending after reset
module three_axis_pid_quad_mixer #(
   parameter int INTEGRAL_WIDTH = tapq_pkg::INTEGRAL_WIDTH
) (
   input  logic                                    clock,
   input  logic                                    reset,
   // sample items
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  tapq_pkg::req_type                       req_data,
   // rotor command items
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output tapq_pkg::rsp_type                       rsp_data,
   // register writes
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [tapq_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [tapq_pkg::GAINS_WIDTH-1:0]        csr_data
);

   localparam int SW = tapq_pkg::SAMPLE_WIDTH;
   localparam int EW = tapq_pkg::effort_width(INTEGRAL_WIDTH);

   // config registers
   logic [tapq_pkg::GAINS_WIDTH-1:0] height_gains_ff, pitch_gains_ff, roll_gains_ff;
   logic signed [SW-1:0]             target_height_ff, target_pitch_ff, target_roll_ff;

   // stage valids: s1 error regs, s2 products, s3 efforts, then result register
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, rsp_valid_ff;

   tapq_pkg::pipe_ctrl_type ctrl;
   logic signed [EW-1:0]    height_effort, pitch_effort, roll_effort;

   // whole pipe moves when the result register is empty or being drained
   always_comb begin
      ctrl.advance = !rsp_valid_ff || rsp_ready;
      ctrl.accept  = req_valid && ctrl.advance;
   end

   assign req_ready = ctrl.advance;
   assign rsp_valid = rsp_valid_ff;
   assign csr_ready = 1'b1;

   // register writes, unknown index ignored, targets keep the low sample bits
   always_ff @(posedge clock) begin
      if (reset) begin
         height_gains_ff  <= tapq_pkg::HEIGHT_GAINS_RESET;
         pitch_gains_ff   <= tapq_pkg::ANGLE_GAINS_RESET;
         roll_gains_ff    <= tapq_pkg::ANGLE_GAINS_RESET;
         target_height_ff <= tapq_pkg::TARGET_HEIGHT_RESET;
         target_pitch_ff  <= tapq_pkg::TARGET_ANGLE_RESET;
         target_roll_ff   <= tapq_pkg::TARGET_ANGLE_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            tapq_pkg::CSR_HEIGHT_GAINS:  height_gains_ff  <= csr_data;
            tapq_pkg::CSR_PITCH_GAINS:   pitch_gains_ff   <= csr_data;
            tapq_pkg::CSR_ROLL_GAINS:    roll_gains_ff    <= csr_data;
            tapq_pkg::CSR_TARGET_HEIGHT: target_height_ff <= csr_data[SW-1:0];
            tapq_pkg::CSR_TARGET_PITCH:  target_pitch_ff  <= csr_data[SW-1:0];
            tapq_pkg::CSR_TARGET_ROLL:   target_roll_ff   <= csr_data[SW-1:0];
            default: ;
         endcase
      end
   end

   // valid bits shift together with the datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.advance) begin
         s1_valid_ff  <= ctrl.accept;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         rsp_valid_ff <= s3_valid_ff;
      end
   end

   tapq_axis #(.INTEGRAL_WIDTH(INTEGRAL_WIDTH)) u_height (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .gains  (height_gains_ff),
      .target (target_height_ff),
      .sample (req_data.height_sample),
      .effort (height_effort)
   );

   tapq_axis #(.INTEGRAL_WIDTH(INTEGRAL_WIDTH)) u_pitch (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .gains  (pitch_gains_ff),
      .target (target_pitch_ff),
      .sample (req_data.pitch_sample),
      .effort (pitch_effort)
   );

   tapq_axis #(.INTEGRAL_WIDTH(INTEGRAL_WIDTH)) u_roll (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .gains  (roll_gains_ff),
      .target (target_roll_ff),
      .sample (req_data.roll_sample),
      .effort (roll_effort)
   );

   // height plus or minus pitch and roll per rotor, then floor and clamp
   tapq_mix #(.INTEGRAL_WIDTH(INTEGRAL_WIDTH)) u_mix (
      .clock         (clock),
      .ctrl          (ctrl),
      .height_effort (height_effort),
      .pitch_effort  (pitch_effort),
      .roll_effort   (roll_effort),
      .rsp           (rsp_data)
   );

`ifndef SYNTHESIS
   ready_when_output_empty: assert property (
      @(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_ready
   ) else $error("input stalled while result register empty");

   accepted_item_enters_pipe: assert property (
      @(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> s1_valid_ff
   ) else $error("accepted item lost at first stage");

   stall_freezes_pipe: assert property (
      @(posedge clock) disable iff (reset)
      !ctrl.advance |=> $stable({s1_valid_ff, s2_valid_ff, s3_valid_ff, rsp_valid_ff})
   ) else $error("pipeline valids moved during a stall");

   last_stage_reaches_output: assert property (
      @(posedge clock) disable iff (reset)
      (s3_valid_ff && ctrl.advance) |=> rsp_valid_ff
   ) else $error("item dropped between effort stage and result register");
`endif

endmodule
